### src/olt_pkg.sv
// Shared types, constants and control structures for the ordered list table.
`timescale 1ns / 1ps

package olt_pkg;

  // List geometry and field widths.
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 5;
  localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int CEXT_W   = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int FEXT_W   = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_WALK  = 2'd2,
    S_DONE  = 2'd3
  } state_t;

  // Input transaction.
  typedef struct packed {
    op_t                     opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  // Result transaction.
  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] found_position;
    logic [CNT_W-1:0] count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_walk;
    logic walk_done;
    logic hit;
  } dp_stat_t;

endpackage

### src/olt_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
`timescale 1ns / 1ps

module olt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  olt_pkg::dp_stat_t stat,
  output logic              busy,
  output olt_pkg::ctrl_cmd_t cmd
);
  import olt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = stat.no_walk ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done || stat.hit) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_CHECK: begin
        cmd.init = !stat.no_walk;
      end
      S_WALK: begin
        cmd.step = 1'b1;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### src/olt_dp.sv
// Datapath: entry memory, length, walk counters and the result register.
`timescale 1ns / 1ps

module olt_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  olt_pkg::in_t       in_item,
  input  olt_pkg::ctrl_cmd_t cmd,
  output olt_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output olt_pkg::out_t      out_item
);
  import olt_pkg::*;

  logic signed [VAL_W-1:0] mem [CAPACITY];

  in_t                     item_r;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [LEN_W-1:0]        rem_r, rem_nxt;
  logic [ADDR_W-1:0]       src_r, src_nxt;
  logic [ADDR_W-1:0]       pdst_r, pdst_nxt;
  logic                    pend_r, pend_nxt;
  logic                    hit_r;
  logic [ADDR_W-1:0]       where_r;
  logic signed [VAL_W-1:0] rdata_r;
  logic                    out_valid_r;
  out_t                    out_r, out_nxt;

  logic [CMP_W-1:0]        len_cmp, pos_cmp;
  logic                    full, range_err, ok;
  logic                    rd_en, wr_en, hit_now;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  status_t                 status;
  logic [CEXT_W-1:0]       cnt_ext;
  logic [FEXT_W-1:0]       fpos_ext;

  // Operation checks against the current length.
  always_comb begin
    len_cmp   = CMP_W'(len_r);
    pos_cmp   = CMP_W'(item_r.position);
    full      = (len_r >= LEN_W'(CAPACITY)) &&
                (item_r.opcode inside {OP_APPEND, OP_INSERT});
    range_err = ((item_r.opcode == OP_INSERT) && (pos_cmp > len_cmp)) ||
                ((item_r.opcode == OP_REMOVE) && (pos_cmp >= len_cmp));
  end

  // Walk control: one read issued while entries remain and one pending entry retired per step cycle.
  always_comb begin
    rem_nxt  = rem_r;
    src_nxt  = src_r;
    pdst_nxt = pdst_r;
    pend_nxt = pend_r;
    rd_en    = 1'b0;
    if (cmd.init) begin
      pend_nxt = 1'b0;
      case (item_r.opcode)
        OP_INSERT: begin
          rem_nxt = LEN_W'(len_cmp - pos_cmp);
          src_nxt = ADDR_W'(len_r - LEN_W'(1));
        end
        OP_REMOVE: begin
          rem_nxt = LEN_W'(len_cmp - pos_cmp - CMP_W'(1));
          src_nxt = ADDR_W'(pos_cmp + CMP_W'(1));
        end
        default: begin
          rem_nxt = len_r;
          src_nxt = '0;
        end
      endcase
    end else if (cmd.step) begin
      pend_nxt = (rem_r != '0);
      if (rem_r != '0) begin
        rd_en   = 1'b1;
        rem_nxt = rem_r - LEN_W'(1);
        case (item_r.opcode)
          OP_INSERT: begin
            pdst_nxt = src_r + ADDR_W'(1);
            src_nxt  = src_r - ADDR_W'(1);
          end
          OP_REMOVE: begin
            pdst_nxt = src_r - ADDR_W'(1);
            src_nxt  = src_r + ADDR_W'(1);
          end
          default: begin
            pdst_nxt = src_r;
            src_nxt  = src_r + ADDR_W'(1);
          end
        endcase
      end
    end
  end

  assign hit_now = cmd.step && pend_r && (item_r.opcode == OP_SEARCH) &&
                   (rdata_r == item_r.value);

  // Status for the controller.
  always_comb begin
    stat.no_walk   = full || range_err || (item_r.opcode == OP_APPEND);
    stat.walk_done = (rem_r == '0) && !pend_r;
    stat.hit       = hit_now;
  end

  // Result status, the walk writes and the final write of the transaction.
  always_comb begin
    if (full) begin
      status = STAT_FULL;
    end else if (range_err) begin
      status = STAT_RANGE;
    end else if ((item_r.opcode == OP_SEARCH) && !hit_r) begin
      status = STAT_NOTFOUND;
    end else begin
      status = STAT_OK;
    end
    ok      = (status == STAT_OK);
    len_nxt = len_r;
    wr_en   = 1'b0;
    wr_addr = pdst_r;
    wr_data = rdata_r;
    if (cmd.step && pend_r && (item_r.opcode inside {OP_INSERT, OP_REMOVE})) begin
      wr_en = 1'b1;
    end
    if (cmd.commit && ok) begin
      case (item_r.opcode)
        OP_APPEND: begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(len_r);
          wr_data = item_r.value;
          len_nxt = len_r + LEN_W'(1);
        end
        OP_INSERT: begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(pos_cmp);
          wr_data = item_r.value;
          len_nxt = len_r + LEN_W'(1);
        end
        OP_REMOVE: begin
          len_nxt = len_r - LEN_W'(1);
        end
        default: begin
          len_nxt = len_r;
        end
      endcase
    end
  end

  // Result fields, masked to their widths.
  always_comb begin
    cnt_ext  = CEXT_W'(len_nxt);
    fpos_ext = FEXT_W'(where_r);
    out_nxt.status         = status;
    out_nxt.count          = cnt_ext[CNT_W-1:0];
    out_nxt.found_position = ((item_r.opcode == OP_SEARCH) && ok) ?
                             fpos_ext[POS_W-1:0] : '0;
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[src_r];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    src_r  <= src_nxt;
    pdst_r <= pdst_nxt;
    if (cmd.init) begin
      hit_r <= 1'b0;
    end else if (hit_now) begin
      hit_r   <= 1'b1;
      where_r <= pdst_r;
    end
    if (cmd.commit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### src/ordered_list_table_core.sv
// Top level of the ordered list table: controller plus datapath.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values with append, insert,
// remove and search. A transaction is taken when start is high and busy is
// low. Exactly one result follows, shown for one cycle with out_valid. It
// cannot be held off, so the receiver must take it in that cycle. Append
// and any rejected operation skip the walk and commit straight after the
// check. Insert, remove and search walk the stored entries one per cycle
// through the entry memory, with one read each cycle and, for insert and
// remove, a write of the entry read the step before. The walk ends early
// when a search meets a match; otherwise it takes one more step after its
// last read to drain that read. The worst case is a search that misses in
// a full list. A search stops at the first match. busy falls as the result
// is produced, so the next transaction may be started in the same cycle
// that the result strobe is high.
module ordered_list_table_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  olt_pkg::in_t   in_item,
  output logic           out_valid,
  output olt_pkg::out_t  out_item
);
  import olt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing.
  olt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Storage and arithmetic.
  olt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Results are never back to back: each needs at least a check and a commit.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // An accepted transaction keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // A result is only produced while the block is still busy with it.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.commit |-> busy)
    else $error("commit outside a transaction");

  // Only a successful search reports a position.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != STAT_OK)) |-> (out_item.found_position == '0))
    else $error("found position reported on a failed operation");

endmodule

### test/ordered_list_table_core_tb.sv
// Self-checking testbench for the ordered list table core.
`timescale 1ns / 1ps

module ordered_list_table_core_tb;
  import olt_pkg::*;

  // Mirror of the list contents and the queue of results still owed by the block.
  class list_scoreboard;
    logic [VAL_W-1:0] slots [CAPACITY];
    int unsigned      fill;
    out_t             results_due [$];
    int unsigned      failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    // Applies one operation to the mirror and returns the result it must produce.
    function out_t list_outcome(in_t item);
      out_t        r;
      int unsigned i;
      bit          hit;
      r.status         = STAT_OK;
      r.found_position = '0;
      hit              = 1'b0;
      case (item.opcode)
        OP_APPEND: begin
          if (fill >= CAPACITY) begin
            r.status = STAT_FULL;
          end else begin
            slots[fill] = item.value;
            fill++;
          end
        end
        OP_INSERT: begin
          // Fullness wins over a bad position.
          if (fill >= CAPACITY) begin
            r.status = STAT_FULL;
          end else if (item.position > fill) begin
            r.status = STAT_RANGE;
          end else begin
            for (i = fill; i > item.position; i--) slots[i] = slots[i-1];
            slots[item.position] = item.value;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (item.position >= fill) begin
            r.status = STAT_RANGE;
          end else begin
            for (i = item.position; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        default: begin
          // The first matching entry is the one reported.
          r.status = STAT_NOTFOUND;
          for (i = 0; i < fill && !hit; i++) begin
            if (slots[i] == item.value) begin
              hit              = 1'b1;
              r.status         = STAT_OK;
              r.found_position = POS_W'(i);
            end
          end
        end
      endcase
      r.count = CNT_W'(fill);
      return r;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // Called for every transaction the block accepts.
    function void note_accepted(in_t item);
      results_due.push_back(list_outcome(item));
    endfunction

    // Called for every result strobe.
    function void check_result(out_t got);
      out_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result with none pending: status %0d pos %0d count %0d",
                         got.status, got.found_position, got.count));
        return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status || got.found_position !== want.found_position ||
          got.count !== want.count) begin
        report($sformatf("mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                         want.status, want.found_position, want.count,
                         got.status, got.found_position, got.count));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  list_scoreboard sb;
  bit             quiet_stretch = 1'b0;

  ordered_list_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Waits a random gap, then offers one transaction until the block takes it.
  task automatic send_op(op_t op, int unsigned pos, logic [VAL_W-1:0] val);
    in_t         item;
    int unsigned gap;
    item.opcode   = op;
    item.position = POS_W'(pos);
    item.value    = val;
    gap = quiet_stretch ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    sb.note_accepted(item);
  endtask

  // Values lean toward a small pool and stored entries so that searches hit.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = VAL_W'($urandom_range(0, 7)) - 32'd4;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'hffff_ffff;
          default: v = 32'h0;
        endcase
      end
      5, 6: v = (sb.fill > 0) ? sb.slots[$urandom_range(0, sb.fill - 1)] : $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic directed_ops();
    int unsigned k;
    // Empty list: every walking operation misses or is out of range.
    send_op(OP_SEARCH, 0, 32'h0);
    send_op(OP_REMOVE, 0, 32'h0);
    send_op(OP_INSERT, 1, 32'h0);
    // Extreme values, an insert at the end and one in the middle.
    send_op(OP_INSERT, 0, 32'h8000_0000);
    send_op(OP_APPEND, 15, 32'h7fff_ffff);
    send_op(OP_INSERT, 2, 32'hffff_ffff);
    send_op(OP_INSERT, 1, 32'd5);
    send_op(OP_APPEND, 0, 32'd5);
    // Duplicate key reports the first position; then a hit and a miss.
    send_op(OP_SEARCH, 15, 32'd5);
    send_op(OP_SEARCH, 0, 32'hffff_ffff);
    send_op(OP_SEARCH, 0, 32'h0);
    // Removes at and past the end, of the last entry and of the first.
    send_op(OP_REMOVE, 5, 32'h0);
    send_op(OP_REMOVE, 15, 32'hffff_ffff);
    send_op(OP_REMOVE, 4, 32'h0);
    send_op(OP_REMOVE, 0, 32'h0);
    send_op(OP_INSERT, 15, 32'h1);
    // Fill to capacity with distinct values.
    for (k = 0; k < 13; k++) send_op(OP_APPEND, k, 32'h0100_0000 + k);
    send_op(OP_APPEND, 0, 32'h2);
    send_op(OP_INSERT, 15, 32'h3);
    send_op(OP_SEARCH, 0, 32'h0100_000c);
    send_op(OP_REMOVE, 15, 32'h0);
    send_op(OP_INSERT, 15, 32'h7fff_ffff);
  endtask

  // Random episodes that push the list toward full, toward empty, or mix all operations more evenly.
  task automatic random_ops(int unsigned total);
    int unsigned sent;
    int unsigned mode;
    int unsigned span;
    int unsigned r;
    int unsigned pos;
    sent = 0;
    while (sent < total) begin
      mode          = $urandom_range(0, 2);
      quiet_stretch = ($urandom_range(0, 3) == 0);
      span          = $urandom_range(10, 40);
      repeat (span) begin
        r = $urandom_range(0, 99);
        if (mode == 0) r = (r < 35) ? 0 : (r < 65) ? 1 : (r < 80) ? 2 : 3;
        else if (mode == 1) r = (r < 10) ? 0 : (r < 20) ? 1 : (r < 60) ? 2 : 3;
        else r = (r < 20) ? 0 : (r < 45) ? 1 : (r < 70) ? 2 : 3;
        case (r)
          0: send_op(OP_APPEND, $urandom_range(0, 15), pick_value());
          1: begin
            pos = ($urandom_range(0, 99) < 85) ? $urandom_range(0, sb.fill)
                                               : $urandom_range(0, 15);
            send_op(OP_INSERT, pos, pick_value());
          end
          2: begin
            pos = (sb.fill > 0 && $urandom_range(0, 99) < 85) ?
                  $urandom_range(0, sb.fill - 1) : $urandom_range(0, 15);
            send_op(OP_REMOVE, pos, pick_value());
          end
          default: begin
            if (sb.fill > 0 && $urandom_range(0, 1) == 1)
              send_op(OP_SEARCH, $urandom_range(0, 15),
                      sb.slots[$urandom_range(0, sb.fill - 1)]);
            else
              send_op(OP_SEARCH, $urandom_range(0, 15), pick_value());
          end
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_ops();
    random_ops(1270);
    quiet_stretch = 1'b0;
    start <= 1'b0;
    // Drain outstanding results, then watch a little longer for strays.
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/olt_pkg.sv
src/olt_ctrl.sv
src/olt_dp.sv
src/ordered_list_table_core.sv
test/ordered_list_table_core_tb.sv
